// ===== hdl/mosi_pkg.sv =====
// Shared types and constants for the motor output safety interlock.
`timescale 1ns / 1ps

package mosi_pkg;

	localparam int PULSE_W = 21;
	localparam logic [PULSE_W-1:0] PULSE_MAX = 21'h1FFFFF;

	localparam logic [15:0] LIMIT_RESET   = 16'd0;
	localparam logic [15:0] TIMEOUT_RESET = 16'd250;

	// config register indexes
	localparam logic CFG_OVERCURRENT_LIMIT = 1'b0;
	localparam logic CFG_COMMAND_TIMEOUT   = 1'b1;

	typedef enum logic [2:0] {
		REQ_NOTE_CMD    = 3'd0,
		REQ_ARM         = 3'd1,
		REQ_DISARM      = 3'd2,
		REQ_CHECK       = 3'd3,
		REQ_ENABLE      = 3'd4,
		REQ_CONTROL     = 3'd5,
		REQ_CLEAR_FAULT = 3'd6,
		REQ_CUT         = 3'd7
	} req_e;

	localparam logic [2:0] CAUSE_OK          = 3'd0;
	localparam logic [2:0] CAUSE_HOST_GONE   = 3'd1;
	localparam logic [2:0] CAUSE_TIMEOUT     = 3'd2;
	localparam logic [2:0] CAUSE_DRV_FAULT   = 3'd3;
	localparam logic [2:0] CAUSE_REQUESTED   = 3'd4;
	localparam logic [2:0] CAUSE_OVERCURRENT = 3'd5;
	localparam logic [2:0] CAUSE_ANGLE_LOST  = 3'd6;

	localparam logic [2:0] EN_OK       = 3'd0;
	localparam logic [2:0] EN_DISARMED = 3'd1;
	localparam logic [2:0] EN_LATCHED  = 3'd2;
	localparam logic [2:0] EN_LINK     = 3'd3;
	localparam logic [2:0] EN_NOZERO   = 3'd4;
	localparam logic [2:0] EN_CAL      = 3'd5;
	localparam logic [2:0] EN_AMP_CFG  = 3'd6;

	typedef struct packed {
		req_e               req;
		logic [31:0]        now_ms;
		logic               host_attached;
		logic               offsets_measured;
		logic               calibrating;
		logic               amp_config_ok;
		logic               driver_fault_pin_low;
		logic [15:0]        pulse_length_ms;
		logic signed [15:0] current_a;
		logic signed [15:0] current_b;
		logic signed [15:0] current_c;
		logic [2:0]         cut_cause;
	} item_t;

	// pulse time is kept as whole ms plus a sub-ms tick remainder
	typedef struct packed {
		logic [2:0]         cause;
		logic               latched;
		logic               armed;
		logic               live;
		logic [31:0]        last_cmd_ms;
		logic [31:0]        trips;
		logic [PULSE_W-1:0] pulse_whole_ms;
		logic [2:0][15:0]   peaks;
	} state_t;

	typedef struct packed {
		logic [2:0]  enable_code;
		logic        clear_accepted;
		logic [2:0]  fault_cause;
		logic        fault_latched;
		logic        is_armed;
		logic        power_live;
		logic [31:0] ms_since_command;
		logic [31:0] trip_count;
		logic [15:0] pulse_left_ms;
		logic [15:0] peak_a;
		logic [15:0] peak_b;
		logic [15:0] peak_c;
	} result_t;

endpackage

// ===== hdl/mosi_event_logic.sv =====
// Per-event next-state and status logic of the interlock.
`timescale 1ns / 1ps

module mosi_event_logic
	import mosi_pkg::*;
#(
	parameter int TICKS_PER_MS = 20,
	parameter int REM_W = 5
) (
	input  item_t            item,
	input  state_t           st,
	input  logic [REM_W-1:0] rem,
	input  logic [15:0]      limit,
	input  logic [15:0]      timeout,
	output state_t           st_n,
	output logic [REM_W-1:0] rem_n,
	output result_t          res
);

	localparam logic [PULSE_W-1:0] SAT_MS = PULSE_W'(PULSE_MAX / TICKS_PER_MS);
	localparam logic [REM_W-1:0] SAT_REM = REM_W'(PULSE_MAX % TICKS_PER_MS);
	localparam logic [REM_W-1:0] REM_TOP = REM_W'(TICKS_PER_MS - 1);
	localparam logic [PULSE_W-1:0] LEFT_MAX = PULSE_W'(16'hFFFF);

	function automatic logic [15:0] magnitude(input logic signed [15:0] v);
		// most negative sample wraps to 0x8000, which reads as 32768
		magnitude = v[15] ? (~v + 16'd1) : v;
	endfunction

	logic [2:0][15:0] mag;
	logic [31:0]      gap;
	logic             over;
	logic             do_cut;
	logic             do_trip;
	logic [2:0]       why;
	logic [2:0]       code;
	logic             clr;
	logic             saturate;

	assign mag[0] = magnitude(item.current_a);
	assign mag[1] = magnitude(item.current_b);
	assign mag[2] = magnitude(item.current_c);
	assign over = (mag[0] > limit) || (mag[1] > limit) || (mag[2] > limit);
	assign gap = item.now_ms - st.last_cmd_ms;
	assign saturate = {5'd0, item.pulse_length_ms} > SAT_MS;

	always_comb begin
		st_n    = st;
		rem_n   = rem;
		do_cut  = 1'b0;
		do_trip = 1'b0;
		why     = CAUSE_REQUESTED;
		code    = EN_OK;
		clr     = 1'b0;

		unique case (item.req)
			REQ_NOTE_CMD: begin
				st_n.last_cmd_ms = item.now_ms;
			end
			REQ_ARM: begin
				if (st.latched) begin
					code = EN_LATCHED;
				end else if (!item.host_attached) begin
					code = EN_LINK;
				end else begin
					st_n.armed = 1'b1;
				end
			end
			REQ_DISARM: begin
				do_cut     = 1'b1;
				st_n.armed = 1'b0;
			end
			REQ_CHECK: begin
				if (!item.host_attached) begin
					st_n.armed = 1'b0;
				end
				if (!st.live) begin
					st_n.last_cmd_ms = item.now_ms;
				end else if (!item.host_attached) begin
					do_cut  = 1'b1;
					do_trip = 1'b1;
					why     = CAUSE_HOST_GONE;
				end else if (!gap[31] && gap >= {16'd0, timeout}) begin
					do_cut  = 1'b1;
					do_trip = 1'b1;
					why     = CAUSE_TIMEOUT;
				end
			end
			REQ_ENABLE: begin
				if (!st.armed) begin
					code = EN_DISARMED;
				end else if (st.latched) begin
					code = EN_LATCHED;
				end else if (!item.host_attached) begin
					code = EN_LINK;
				end else if (!item.offsets_measured) begin
					code = EN_NOZERO;
				end else if (item.calibrating) begin
					code = EN_CAL;
				end else if (!item.amp_config_ok) begin
					code = EN_AMP_CFG;
				end else begin
					st_n.last_cmd_ms    = item.now_ms;
					st_n.cause          = CAUSE_OK;
					st_n.peaks          = '0;
					st_n.live           = 1'b1;
					st_n.pulse_whole_ms = saturate ? SAT_MS : {5'd0, item.pulse_length_ms};
					rem_n               = saturate ? SAT_REM : '0;
				end
			end
			REQ_CONTROL: begin
				if (st.live) begin
					for (int i = 0; i < 3; i++) begin
						if (mag[i] > st.peaks[i]) begin
							st_n.peaks[i] = mag[i];
						end
					end
					if (over) begin
						do_cut  = 1'b1;
						do_trip = 1'b1;
						why     = CAUSE_OVERCURRENT;
					end else if (st.pulse_whole_ms != '0 || rem != '0) begin
						if (rem == '0) begin
							st_n.pulse_whole_ms = st.pulse_whole_ms - PULSE_W'(1);
							rem_n               = REM_TOP;
						end else begin
							rem_n = rem - REM_W'(1);
						end
						// pulse just ran out: requested stop
						if (st_n.pulse_whole_ms == '0 && rem_n == '0) begin
							do_cut = 1'b1;
						end
					end
				end
			end
			REQ_CLEAR_FAULT: begin
				if (!st.latched) begin
					clr = 1'b1;
				end else if (!item.host_attached) begin
					clr = 1'b0;
				end else if (st.cause == CAUSE_DRV_FAULT && item.driver_fault_pin_low) begin
					clr = 1'b0;
				end else begin
					st_n.latched     = 1'b0;
					st_n.cause       = CAUSE_OK;
					st_n.last_cmd_ms = item.now_ms;
					clr              = 1'b1;
				end
			end
			REQ_CUT: begin
				if (item.cut_cause >= CAUSE_HOST_GONE && item.cut_cause <= CAUSE_ANGLE_LOST) begin
					do_cut = 1'b1;
					why    = item.cut_cause;
				end
			end
			default: begin
			end
		endcase

		if (do_cut) begin
			st_n.live           = 1'b0;
			st_n.pulse_whole_ms = '0;
			rem_n               = '0;
			if (!st.latched) begin
				st_n.cause = why;
			end
			if (why != CAUSE_REQUESTED) begin
				st_n.latched = 1'b1;
				st_n.armed   = 1'b0;
			end
		end
		if (do_trip) begin
			st_n.trips = st.trips + 32'd1;
		end
	end

	always_comb begin
		res.enable_code      = code;
		res.clear_accepted   = clr;
		res.fault_cause      = st_n.cause;
		res.fault_latched    = st_n.latched;
		res.is_armed         = st_n.armed;
		res.power_live       = st_n.live;
		res.ms_since_command = item.now_ms - st_n.last_cmd_ms;
		res.trip_count       = st_n.trips;
		res.pulse_left_ms    = (st_n.pulse_whole_ms > LEFT_MAX) ? 16'hFFFF
			: st_n.pulse_whole_ms[15:0];
		res.peak_a           = st_n.peaks[0];
		res.peak_b           = st_n.peaks[1];
		res.peak_c           = st_n.peaks[2];
	end

endmodule

// ===== hdl/motor_output_safety_interlock_unit.sv =====
// Top level of the motor output safety interlock: pipeline, state and config registers.
// An event beat accepted into stage 1 is evaluated against the state, and its status is
// registered in the result register; an undrained full result register stalls stage 1.
// Throughput: one event per cycle while status is drained; each sees the last one's state.
// Reset: arst_n clears all flags, counters, peaks and the pipeline valids at once,
// and loads the config registers with their reset values.
`timescale 1ns / 1ps

module motor_output_safety_interlock_unit
	import mosi_pkg::*;
#(
	parameter int TICKS_PER_MS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [31:0]        now_ms,
	input  logic               host_attached,
	input  logic               offsets_measured,
	input  logic               calibrating,
	input  logic               amp_config_ok,
	input  logic               driver_fault_pin_low,
	input  logic [15:0]        pulse_length_ms,
	input  logic signed [15:0] current_a,
	input  logic signed [15:0] current_b,
	input  logic signed [15:0] current_c,
	input  logic [2:0]         cut_cause,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         enable_code,
	output logic               clear_accepted,
	output logic [2:0]         fault_cause,
	output logic               fault_latched,
	output logic               is_armed,
	output logic               power_live,
	output logic [31:0]        ms_since_command,
	output logic [31:0]        trip_count,
	output logic [15:0]        pulse_left_ms,
	output logic [15:0]        peak_a,
	output logic [15:0]        peak_b,
	output logic [15:0]        peak_c
);

	localparam int REM_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;

	logic [15:0]      limit_q;
	logic [15:0]      timeout_q;
	state_t           st_q;
	state_t           st_n;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] rem_n;
	item_t            item_in;
	item_t            item_s1;
	logic             valid_s1;
	result_t          res_n;
	result_t          res_s2;
	logic             valid_s2;
	logic             advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= LIMIT_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OVERCURRENT_LIMIT: limit_q <= cfg_data;
				CFG_COMMAND_TIMEOUT:   timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		item_in.req                  = req_e'(req_type);
		item_in.now_ms               = now_ms;
		item_in.host_attached        = host_attached;
		item_in.offsets_measured     = offsets_measured;
		item_in.calibrating          = calibrating;
		item_in.amp_config_ok        = amp_config_ok;
		item_in.driver_fault_pin_low = driver_fault_pin_low;
		item_in.pulse_length_ms      = pulse_length_ms;
		item_in.current_a            = current_a;
		item_in.current_b            = current_b;
		item_in.current_c            = current_c;
		item_in.cut_cause            = cut_cause;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			res_s2 <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			rem_q <= '0;
		end else if (advance) begin
			st_q  <= st_n;
			rem_q <= rem_n;
		end
	end

	mosi_event_logic #(
		.TICKS_PER_MS(TICKS_PER_MS),
		.REM_W       (REM_W)
	) u_event (
		.item   (item_s1),
		.st     (st_q),
		.rem    (rem_q),
		.limit  (limit_q),
		.timeout(timeout_q),
		.st_n   (st_n),
		.rem_n  (rem_n),
		.res    (res_n)
	);

	assign out_valid        = valid_s2;
	assign enable_code      = res_s2.enable_code;
	assign clear_accepted   = res_s2.clear_accepted;
	assign fault_cause      = res_s2.fault_cause;
	assign fault_latched    = res_s2.fault_latched;
	assign is_armed         = res_s2.is_armed;
	assign power_live       = res_s2.power_live;
	assign ms_since_command = res_s2.ms_since_command;
	assign trip_count       = res_s2.trip_count;
	assign pulse_left_ms    = res_s2.pulse_left_ms;
	assign peak_a           = res_s2.peak_a;
	assign peak_b           = res_s2.peak_b;
	assign peak_c           = res_s2.peak_c;

	// live power stage needs an armed, unlatched interlock
	a_live_safe: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.live |-> (st_q.armed && !st_q.latched))
		else $error("outputs live while disarmed or latched");

	a_latched_cause: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.latched |-> (st_q.cause != CAUSE_OK))
		else $error("fault latched with no cause");

	a_trip_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (st_q.trips == $past(st_q.trips) || st_q.trips == $past(st_q.trips) + 32'd1))
		else $error("trip count jumped");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		{{(32 - REM_W){1'b0}}, rem_q} < 32'(TICKS_PER_MS))
		else $error("pulse tick remainder out of range");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("state changed without an event");

endmodule

// ===== verif/motor_output_safety_interlock_unit_tb.sv =====
// Self-checking testbench for the motor output safety interlock: directed and random events.
`timescale 1ns / 1ps

module motor_output_safety_interlock_unit_tb;
	import mosi_pkg::*;

	localparam int MS_TICKS    = 20;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_OVERCURRENT_LIMIT;
	logic [15:0] cfg_data = '0;

	logic  in_valid = 1'b0;
	logic  in_ready;
	item_t cur = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  enable_code;
	logic        clear_accepted;
	logic [2:0]  fault_cause;
	logic        fault_latched;
	logic        is_armed;
	logic        power_live;
	logic [31:0] ms_since_command;
	logic [31:0] trip_count;
	logic [15:0] pulse_left_ms;
	logic [15:0] peak_a;
	logic [15:0] peak_b;
	logic [15:0] peak_c;

	always #4 clk = ~clk;

	motor_output_safety_interlock_unit #(
		.TICKS_PER_MS(MS_TICKS)
	) i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.req_type            (cur.req),
		.now_ms              (cur.now_ms),
		.host_attached       (cur.host_attached),
		.offsets_measured    (cur.offsets_measured),
		.calibrating         (cur.calibrating),
		.amp_config_ok       (cur.amp_config_ok),
		.driver_fault_pin_low(cur.driver_fault_pin_low),
		.pulse_length_ms     (cur.pulse_length_ms),
		.current_a           (cur.current_a),
		.current_b           (cur.current_b),
		.current_c           (cur.current_c),
		.cut_cause           (cur.cut_cause),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.enable_code         (enable_code),
		.clear_accepted      (clear_accepted),
		.fault_cause         (fault_cause),
		.fault_latched       (fault_latched),
		.is_armed            (is_armed),
		.power_live          (power_live),
		.ms_since_command    (ms_since_command),
		.trip_count          (trip_count),
		.pulse_left_ms       (pulse_left_ms),
		.peak_a              (peak_a),
		.peak_b              (peak_b),
		.peak_c              (peak_c)
	);

	item_t   events_todo[$];
	result_t status_due[$];
	int      mismatches = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      hold_asked = 0;
	int      hold_done = 0;
	int      hold_left = 0;
	int      quiet_cycles = 0;
	logic [31:0] sim_ms = 32'd0;

	// interlock state as the block should hold it
	logic [15:0]        lim_now = LIMIT_RESET;
	logic [15:0]        tmo_now = TIMEOUT_RESET;
	logic [2:0]         st_cause = CAUSE_OK;
	logic               st_latched = 1'b0;
	logic               st_armed = 1'b0;
	logic               st_live = 1'b0;
	logic [31:0]        st_last_cmd = '0;
	logic [31:0]        st_trips = '0;
	logic [PULSE_W-1:0] st_ticks = '0;
	logic [15:0]        st_peak [3] = '{16'd0, 16'd0, 16'd0};

	task automatic log_mismatch(input string what);
		if (mismatches < 50)
			$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic cut_power(input logic [2:0] why);
		st_live = 1'b0;
		st_ticks = '0;
		if (!st_latched)
			st_cause = why;
		if (why != CAUSE_REQUESTED) begin
			st_latched = 1'b1;
			st_armed = 1'b0;
		end
	endtask

	function automatic logic [15:0] magnitude(input logic signed [15:0] x);
		logic [15:0] u;
		u = x;
		return u[15] ? (~u + 16'd1) : u;
	endfunction

	task automatic apply_event(input item_t e, output result_t r);
		logic [15:0] mag [3];
		logic [31:0] gap;
		logic [31:0] scaled;
		logic [31:0] left;
		logic        over;
		logic [2:0]  code;
		logic        clr;
		code = EN_OK;
		clr = 1'b0;
		case (e.req)
			REQ_NOTE_CMD: st_last_cmd = e.now_ms;
			REQ_ARM: begin
				if (st_latched)
					code = EN_LATCHED;
				else if (!e.host_attached)
					code = EN_LINK;
				else
					st_armed = 1'b1;
			end
			REQ_DISARM: begin
				cut_power(CAUSE_REQUESTED);
				st_armed = 1'b0;
			end
			REQ_CHECK: begin
				if (!e.host_attached)
					st_armed = 1'b0;
				if (!st_live) begin
					st_last_cmd = e.now_ms;
				end else if (!e.host_attached) begin
					cut_power(CAUSE_HOST_GONE);
					st_trips++;
				end else begin
					// a gap that reads negative never times out
					gap = e.now_ms - st_last_cmd;
					if (!gap[31] && gap >= {16'd0, tmo_now}) begin
						cut_power(CAUSE_TIMEOUT);
						st_trips++;
					end
				end
			end
			REQ_ENABLE: begin
				if (!st_armed)
					code = EN_DISARMED;
				else if (st_latched)
					code = EN_LATCHED;
				else if (!e.host_attached)
					code = EN_LINK;
				else if (!e.offsets_measured)
					code = EN_NOZERO;
				else if (e.calibrating)
					code = EN_CAL;
				else if (!e.amp_config_ok)
					code = EN_AMP_CFG;
				else begin
					scaled = {16'd0, e.pulse_length_ms} * MS_TICKS;
					st_last_cmd = e.now_ms;
					st_cause = CAUSE_OK;
					st_peak = '{16'd0, 16'd0, 16'd0};
					st_ticks = (scaled > PULSE_MAX) ? PULSE_MAX : scaled[PULSE_W-1:0];
					st_live = 1'b1;
				end
			end
			REQ_CONTROL: begin
				if (st_live) begin
					mag[0] = magnitude(e.current_a);
					mag[1] = magnitude(e.current_b);
					mag[2] = magnitude(e.current_c);
					over = 1'b0;
					for (int i = 0; i < 3; i++) begin
						if (mag[i] > st_peak[i])
							st_peak[i] = mag[i];
						if (mag[i] > lim_now)
							over = 1'b1;
					end
					if (over) begin
						cut_power(CAUSE_OVERCURRENT);
						st_trips++;
					end else if (st_ticks != '0) begin
						st_ticks--;
						if (st_ticks == '0)
							cut_power(CAUSE_REQUESTED);
					end
				end
			end
			REQ_CLEAR_FAULT: begin
				if (!st_latched)
					clr = 1'b1;
				else if (!e.host_attached)
					clr = 1'b0;
				else if (st_cause == CAUSE_DRV_FAULT && e.driver_fault_pin_low)
					clr = 1'b0;
				else begin
					st_latched = 1'b0;
					st_cause = CAUSE_OK;
					st_last_cmd = e.now_ms;
					clr = 1'b1;
				end
			end
			REQ_CUT: begin
				if (e.cut_cause >= CAUSE_HOST_GONE && e.cut_cause <= CAUSE_ANGLE_LOST)
					cut_power(e.cut_cause);
			end
		endcase
		left = {11'd0, st_ticks} / MS_TICKS;
		if (left > 32'hFFFF)
			left = 32'hFFFF;
		r.enable_code = code;
		r.clear_accepted = clr;
		r.fault_cause = st_cause;
		r.fault_latched = st_latched;
		r.is_armed = st_armed;
		r.power_live = st_live;
		r.ms_since_command = e.now_ms - st_last_cmd;
		r.trip_count = st_trips;
		r.pulse_left_ms = left[15:0];
		r.peak_a = st_peak[0];
		r.peak_b = st_peak[1];
		r.peak_c = st_peak[2];
	endtask

	// sender: a new beat goes out whenever the slot is free and the idle draw allows
	always @(posedge clk) begin : sender
		result_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				apply_event(cur, r);
				status_due.push_back(r);
			end
			if (!in_valid || in_ready) begin
				if (events_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur <= events_todo.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_asked != hold_done) begin
			hold_done <= hold_asked;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : status_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (status_due.size() == 0) begin
				log_mismatch("status beat with nothing expected");
			end else begin
				want = status_due.pop_front();
				check_field("enable_code", 32'(enable_code), 32'(want.enable_code));
				check_field("clear_accepted", 32'(clear_accepted), 32'(want.clear_accepted));
				check_field("fault_cause", 32'(fault_cause), 32'(want.fault_cause));
				check_field("fault_latched", 32'(fault_latched), 32'(want.fault_latched));
				check_field("is_armed", 32'(is_armed), 32'(want.is_armed));
				check_field("power_live", 32'(power_live), 32'(want.power_live));
				check_field("ms_since_command", ms_since_command, want.ms_since_command);
				check_field("trip_count", trip_count, want.trip_count);
				check_field("pulse_left_ms", 32'(pulse_left_ms), 32'(want.pulse_left_ms));
				check_field("peak_a", 32'(peak_a), 32'(want.peak_a));
				check_field("peak_b", 32'(peak_b), 32'(want.peak_b));
				check_field("peak_c", 32'(peak_c), 32'(want.peak_c));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic cfg_write(input logic idx, input logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_OVERCURRENT_LIMIT)
			lim_now = data;
		else
			tmo_now = data;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (events_todo.size() != 0 || in_valid || status_due.size() != 0);
	endtask

	function automatic item_t calm_event(input req_e r, input logic [31:0] t);
		item_t e;
		e = '0;
		e.req = r;
		e.now_ms = t;
		e.host_attached = 1'b1;
		e.offsets_measured = 1'b1;
		e.amp_config_ok = 1'b1;
		e.cut_cause = CAUSE_REQUESTED;
		return e;
	endfunction

	function automatic item_t noise_event();
		item_t e;
		e.req = req_e'(3'($urandom_range(0, 7)));
		e.now_ms = $urandom;
		e.host_attached = 1'($urandom_range(0, 1));
		e.offsets_measured = 1'($urandom_range(0, 1));
		e.calibrating = 1'($urandom_range(0, 1));
		e.amp_config_ok = 1'($urandom_range(0, 1));
		e.driver_fault_pin_low = 1'($urandom_range(0, 1));
		e.pulse_length_ms = 16'($urandom);
		e.current_a = 16'($urandom);
		e.current_b = 16'($urandom);
		e.current_c = 16'($urandom);
		e.cut_cause = 3'($urandom_range(0, 7));
		return e;
	endfunction

	// mostly under the limit, sometimes anything at all
	function automatic logic [15:0] pick_current(input logic [15:0] lim);
		logic [15:0] m;
		if ($urandom_range(0, 9) < 2)
			return 16'($urandom);
		m = 16'($urandom_range(0, (lim > 16'd32767) ? 32767 : lim));
		return $urandom_range(0, 1) ? (~m + 16'd1) : m;
	endfunction

	task automatic queue_sessions(input int n, input logic [15:0] lim, input logic [15:0] tmo);
		item_t e;
		int    queued;
		int    steps;
		int    pick;
		queued = 0;
		while (queued < n) begin
			if ($urandom_range(0, 9) < 3) begin
				events_todo.push_back(noise_event());
				queued++;
			end else begin
				if ($urandom_range(0, 1)) begin
					e = calm_event(REQ_CLEAR_FAULT, sim_ms);
					e.driver_fault_pin_low = ($urandom_range(0, 4) == 0);
					events_todo.push_back(e);
					queued++;
				end
				events_todo.push_back(calm_event(REQ_NOTE_CMD, sim_ms));
				e = calm_event(REQ_ARM, sim_ms);
				e.host_attached = ($urandom_range(0, 9) != 0);
				events_todo.push_back(e);
				e = calm_event(REQ_ENABLE, sim_ms);
				if ($urandom_range(0, 6) == 0) begin
					case ($urandom_range(0, 3))
						0: e.host_attached = 1'b0;
						1: e.offsets_measured = 1'b0;
						2: e.calibrating = 1'b1;
						default: e.amp_config_ok = 1'b0;
					endcase
				end
				pick = $urandom_range(0, 9);
				e.pulse_length_ms = (pick < 4) ? 16'd0 : (pick < 8) ? 16'($urandom_range(1, 2))
					: 16'($urandom);
				events_todo.push_back(e);
				queued += 3;
				steps = $urandom_range(1, 45);
				for (int s = 0; s < steps; s++) begin
					sim_ms += $urandom_range(0, tmo / 8 + 1);
					pick = $urandom_range(0, 19);
					if (pick < 14) begin
						e = calm_event(REQ_CONTROL, sim_ms);
						e.current_a = pick_current(lim);
						e.current_b = pick_current(lim);
						e.current_c = pick_current(lim);
					end else if (pick < 16) begin
						e = calm_event(REQ_CHECK, sim_ms);
						e.host_attached = ($urandom_range(0, 9) != 0);
					end else if (pick < 18) begin
						e = calm_event(REQ_NOTE_CMD, sim_ms);
					end else if (pick < 19) begin
						e = calm_event(REQ_CUT, sim_ms);
						e.cut_cause = 3'($urandom_range(0, 7));
					end else begin
						e = calm_event($urandom_range(0, 1) ? REQ_DISARM : REQ_ARM, sim_ms);
					end
					events_todo.push_back(e);
					queued++;
				end
				if ($urandom_range(0, 19) == 0)
					sim_ms = $urandom;
			end
		end
	endtask

	initial begin
		item_t       e;
		logic [15:0] lim_set [4] = '{16'd1000, 16'hFFFF, 16'd0, 16'd20000};
		logic [15:0] tmo_set [4] = '{16'd250, 16'd1, 16'hFFFF, 16'd40};
		int          idle_set [4] = '{0, 67, 0, 25};
		int          stall_set [4] = '{0, 0, 67, 25};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		cfg_write(CFG_OVERCURRENT_LIMIT, 16'd100);
		cfg_write(CFG_COMMAND_TIMEOUT, 16'd250);

		events_todo.push_back(calm_event(REQ_ENABLE, 32'd10));
		e = calm_event(REQ_ARM, 32'd10);
		e.host_attached = 1'b0;
		events_todo.push_back(e);
		events_todo.push_back(calm_event(REQ_ARM, 32'd10));
		e = calm_event(REQ_ENABLE, 32'd20);
		e.host_attached = 1'b0;
		events_todo.push_back(e);
		e = calm_event(REQ_ENABLE, 32'd20);
		e.offsets_measured = 1'b0;
		events_todo.push_back(e);
		e = calm_event(REQ_ENABLE, 32'd20);
		e.calibrating = 1'b1;
		events_todo.push_back(e);
		e = calm_event(REQ_ENABLE, 32'd20);
		e.amp_config_ok = 1'b0;
		events_todo.push_back(e);
		e = calm_event(REQ_ENABLE, 32'd1000);
		e.pulse_length_ms = 16'd1;
		events_todo.push_back(e);
		// full-scale currents on two phases, the negative one at its most negative
		e = calm_event(REQ_CONTROL, 32'd1001);
		e.current_a = 16'sh8000;
		e.current_b = 16'sh7FFF;
		events_todo.push_back(e);
		e = calm_event(REQ_CUT, 32'd1002);
		e.cut_cause = CAUSE_HOST_GONE;
		events_todo.push_back(e);
		events_todo.push_back(calm_event(REQ_ARM, 32'd1003));
		e = calm_event(REQ_CLEAR_FAULT, 32'd1004);
		e.host_attached = 1'b0;
		events_todo.push_back(e);
		events_todo.push_back(calm_event(REQ_CLEAR_FAULT, 32'd1005));
		events_todo.push_back(calm_event(REQ_CLEAR_FAULT, 32'd1006));
		e = calm_event(REQ_CUT, 32'd1007);
		e.cut_cause = CAUSE_OK;
		events_todo.push_back(e);
		e.cut_cause = 3'd7;
		events_todo.push_back(e);
		e.cut_cause = CAUSE_DRV_FAULT;
		events_todo.push_back(e);
		e = calm_event(REQ_CLEAR_FAULT, 32'd1008);
		e.driver_fault_pin_low = 1'b1;
		events_todo.push_back(e);
		events_todo.push_back(calm_event(REQ_CLEAR_FAULT, 32'd1009));
		events_todo.push_back(calm_event(REQ_ARM, 32'd1010));
		e = calm_event(REQ_ENABLE, 32'hFFFF_FFF0);
		e.pulse_length_ms = 16'hFFFF;
		events_todo.push_back(e);
		// gap across the wrap, then a gap that reads negative, then a real timeout
		events_todo.push_back(calm_event(REQ_CHECK, 32'h0000_0010));
		events_todo.push_back(calm_event(REQ_CHECK, 32'hFFFF_FF00));
		events_todo.push_back(calm_event(REQ_CHECK, 32'h0000_00F0));
		events_todo.push_back(calm_event(REQ_DISARM, 32'h0000_0100));
		events_todo.push_back(calm_event(REQ_CLEAR_FAULT, 32'd400));
		events_todo.push_back(calm_event(REQ_ARM, 32'd410));
		events_todo.push_back(calm_event(REQ_ENABLE, 32'd500));
		e = calm_event(REQ_CHECK, 32'd510);
		e.host_attached = 1'b0;
		events_todo.push_back(e);
		wait_drained();

		sim_ms = 32'd2000;
		for (int p = 0; p < 4; p++) begin
			cfg_write(CFG_OVERCURRENT_LIMIT, lim_set[p]);
			cfg_write(CFG_COMMAND_TIMEOUT, tmo_set[p]);
			send_idle_pct = idle_set[p];
			recv_stall_pct = stall_set[p];
			queue_sessions(150, lim_set[p], tmo_set[p]);
			// sink stops for a while so the pipe backs up into the input
			if (p == 0)
				hold_asked++;
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (status_due.size() != 0)
			log_mismatch($sformatf("%0d status beats never arrived", status_due.size()));
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mosi_pkg.sv
hdl/mosi_event_logic.sv
hdl/motor_output_safety_interlock_unit.sv
verif/motor_output_safety_interlock_unit_tb.sv
